FILE: hdl/camera_vertex_transform_assert.svh
// assertion macros shared by the block
`ifndef CAMERA_VERTEX_TRANSFORM_ASSERT_SVH
`define CAMERA_VERTEX_TRANSFORM_ASSERT_SVH

// plain implication check, off during reset
`define CVT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("camera_vertex_transform: check failed");

// check that a signal follows another after a fixed count
`define CVT_ASSERT_DELAY(lbl, now, then, n) \
   lbl: assert property (@(posedge clock) disable iff (reset) (then) |-> ##(n) (now)) \
      else $error("camera_vertex_transform: latency check failed");

`endif

FILE: hdl/cvt_pkg.sv
package cvt_pkg;

   localparam int DIVIDEND_W = 47;
   localparam int ROT_LAT    = 5;
   localparam int DIV_LAT    = DIVIDEND_W + 2;
   localparam int PRJ_LAT    = 2;
   localparam int LATENCY    = ROT_LAT + DIV_LAT + PRJ_LAT;

   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;

   typedef enum logic [2:0] {
      CSR_CAMERA_X     = 3'd0,
      CSR_CAMERA_Y     = 3'd1,
      CSR_CAMERA_Z     = 3'd2,
      CSR_SINE_PITCH   = 3'd3,
      CSR_COSINE_PITCH = 3'd4,
      CSR_SINE_YAW     = 3'd5,
      CSR_COSINE_YAW   = 3'd6,
      CSR_FOCAL        = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] camera_x;
      logic signed [31:0] camera_y;
      logic signed [31:0] camera_z;
      logic signed [15:0] sine_pitch;
      logic signed [15:0] cosine_pitch;
      logic signed [15:0] sine_yaw;
      logic signed [15:0] cosine_yaw;
      logic [30:0]        focal_distance;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] x1;
      logic signed [31:0] y1;
      logic signed [31:0] z2;
   } view_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)
         return S32_MAX;
      else if (v < -64'sd2147483648)
         return S32_MIN;
      else
         return v[31:0];
   endfunction

endpackage

FILE: hdl/cvt_rotate.sv
module cvt_rotate (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic signed [31:0] vertex_x,
   input  logic signed [31:0] vertex_y,
   input  logic signed [31:0] vertex_z,
   input  cvt_pkg::cfg_type  cfg,
   output logic              out_valid,
   output cvt_pkg::view_type out_view
);
   import cvt_pkg::*;

   logic [ROT_LAT-1:0] vld_ff;
   logic signed [31:0] tx_ff, ty_ff, tz_ff;
   logic signed [47:0] p_cx_ff, p_sz_ff, p_cz_ff, p_sx_ff;
   logic signed [31:0] ty_b_ff, ty_c_ff;
   logic signed [31:0] x1_ff, z1_ff, x1_d_ff;
   logic signed [47:0] p_cy_ff, p_sz1_ff, p_sy_ff, p_cz1_ff;
   logic signed [31:0] x1_e_ff, y1_ff, z2_ff;
   logic signed [31:0] tx_in, ty_in, tz_in, x1_in, z1_in, y1_in, z2_in;

   always_comb begin
      tx_in = sat32(64'(vertex_x) - 64'(cfg.camera_x));
      ty_in = sat32(64'(vertex_y) - 64'(cfg.camera_y));
      tz_in = sat32(64'(vertex_z) - 64'(cfg.camera_z));
      x1_in = sat32((64'(p_cx_ff) + 64'(p_sz_ff)) >>> 14);
      z1_in = sat32((64'(p_cz_ff) - 64'(p_sx_ff)) >>> 14);
      y1_in = sat32((64'(p_cy_ff) - 64'(p_sz1_ff)) >>> 14);
      z2_in = sat32((64'(p_sy_ff) + 64'(p_cz1_ff)) >>> 14);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ROT_LAT-2:0], in_valid};
      end
      // translate
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      tz_ff    <= tz_in;
      // yaw products
      p_cx_ff  <= cfg.cosine_yaw * tx_ff;
      p_sz_ff  <= cfg.sine_yaw * tz_ff;
      p_cz_ff  <= cfg.cosine_yaw * tz_ff;
      p_sx_ff  <= cfg.sine_yaw * tx_ff;
      ty_b_ff  <= ty_ff;
      x1_ff    <= x1_in;
      z1_ff    <= z1_in;
      ty_c_ff  <= ty_b_ff;
      // pitch products
      p_cy_ff  <= cfg.cosine_pitch * ty_c_ff;
      p_sz1_ff <= cfg.sine_pitch * z1_ff;
      p_sy_ff  <= cfg.sine_pitch * ty_c_ff;
      p_cz1_ff <= cfg.cosine_pitch * z1_ff;
      x1_d_ff  <= x1_ff;
      x1_e_ff  <= x1_d_ff;
      y1_ff    <= y1_in;
      z2_ff    <= z2_in;
   end

   assign out_valid   = vld_ff[ROT_LAT-1];
   assign out_view.x1 = x1_e_ff;
   assign out_view.y1 = y1_ff;
   assign out_view.z2 = z2_ff;
endmodule

FILE: hdl/cvt_divider.sv
module cvt_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cvt_pkg::view_type  in_view,
   input  logic [30:0]        focal_distance,
   output logic               out_valid,
   output cvt_pkg::view_type  out_view,
   output logic signed [31:0] out_scale
);
   import cvt_pkg::*;

   typedef struct packed {
      view_type               view;
      logic                   neg;
      logic                   zero;
      logic [31:0]            dvs;
      logic [31:0]            rem;
      logic [DIVIDEND_W-1:0]  num;
      logic [DIVIDEND_W-1:0]  quo;
   } div_stage_type;

   logic [DIVIDEND_W:0] vld_ff;
   div_stage_type       stage_ff [DIVIDEND_W+1];
   logic                out_vld_ff;
   view_type            view_ff;
   logic signed [31:0]  scale_ff, scale_in;
   div_stage_type       last;

   // magnitude of the depth and the dividend
   always_ff @(posedge clock) begin
      stage_ff[0].view <= in_view;
      stage_ff[0].neg  <= in_view.z2[31];
      stage_ff[0].zero <= (in_view.z2 == '0);
      stage_ff[0].dvs  <= in_view.z2[31] ? 32'(-in_view.z2) : in_view.z2;
      stage_ff[0].rem  <= '0;
      stage_ff[0].num  <= {focal_distance, 16'b0};
      stage_ff[0].quo  <= '0;
   end

   // one quotient bit per stage, restoring
   for (genvar i = 1; i <= DIVIDEND_W; i++) begin : g_step
      logic [32:0] shifted, diff;
      logic        ge;
      always_comb begin
         shifted = {stage_ff[i-1].rem, stage_ff[i-1].num[DIVIDEND_W-1]};
         diff    = shifted - {1'b0, stage_ff[i-1].dvs};
         ge      = shifted >= {1'b0, stage_ff[i-1].dvs};
      end
      always_ff @(posedge clock) begin
         stage_ff[i].view <= stage_ff[i-1].view;
         stage_ff[i].neg  <= stage_ff[i-1].neg;
         stage_ff[i].zero <= stage_ff[i-1].zero;
         stage_ff[i].dvs  <= stage_ff[i-1].dvs;
         stage_ff[i].rem  <= ge ? diff[31:0] : shifted[31:0];
         stage_ff[i].num  <= {stage_ff[i-1].num[DIVIDEND_W-2:0], 1'b0};
         stage_ff[i].quo  <= {stage_ff[i-1].quo[DIVIDEND_W-2:0], ge};
      end
   end

   always_comb begin
      last = stage_ff[DIVIDEND_W];
      if (last.zero)
         scale_in = S32_MAX;
      else if (!last.neg)
         scale_in = (last.quo > DIVIDEND_W'(32'h7fffffff)) ? S32_MAX : last.quo[31:0];
      else
         scale_in = (last.quo > DIVIDEND_W'(33'h80000000)) ? S32_MIN
                                                            : 32'(-last.quo[31:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= {vld_ff[DIVIDEND_W-1:0], in_valid};
         out_vld_ff <= vld_ff[DIVIDEND_W];
      end
      view_ff  <= last.view;
      scale_ff <= scale_in;
   end

   assign out_valid = out_vld_ff;
   assign out_view  = view_ff;
   assign out_scale = scale_ff;
endmodule

FILE: hdl/cvt_project.sv
module cvt_project #(
   parameter int CENTER_X = 320,
   parameter int CENTER_Y = 240
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cvt_pkg::view_type  in_view,
   input  logic signed [31:0] in_scale,
   output logic               out_valid,
   output logic signed [31:0] screen_x,
   output logic signed [31:0] screen_y,
   output logic signed [31:0] view_depth,
   output logic signed [31:0] depth_scale,
   output logic               behind_camera
);
   import cvt_pkg::*;

   localparam logic signed [63:0] HW_Q = 64'(CENTER_X) * 64'sd65536;
   localparam logic signed [63:0] HH_Q = 64'(CENTER_Y) * 64'sd65536;

   logic [PRJ_LAT-1:0] vld_ff;
   logic signed [63:0] mx_ff, my_ff;
   logic signed [31:0] z2_ff, scale_ff;
   logic signed [31:0] sx_ff, sy_ff, depth_ff, dscale_ff;
   logic               behind_ff;
   logic signed [31:0] sx_in, sy_in;

   always_comb begin
      sx_in = sat32((mx_ff >>> 16) + HW_Q);
      sy_in = sat32((my_ff >>> 16) + HH_Q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PRJ_LAT-2:0], in_valid};
      end
      mx_ff     <= 64'(in_view.x1) * 64'(in_scale);
      my_ff     <= 64'(in_view.y1) * 64'(in_scale);
      z2_ff     <= in_view.z2;
      scale_ff  <= in_scale;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      depth_ff  <= z2_ff;
      dscale_ff <= scale_ff;
      behind_ff <= z2_ff[31] || (z2_ff == '0);
   end

   assign out_valid     = vld_ff[PRJ_LAT-1];
   assign screen_x      = sx_ff;
   assign screen_y      = sy_ff;
   assign view_depth    = depth_ff;
   assign depth_scale   = dscale_ff;
   assign behind_camera = behind_ff;
endmodule

FILE: hdl/camera_vertex_transform.sv
// channel   | ports                                   | handshake
// request   | req_vertex_x/y/z                        | start, busy
// response  | rsp_screen_x/y, rsp_view_depth,         | rsp_valid strobe
//           | rsp_depth_scale, rsp_behind_camera      |
// csr write | csr_index, csr_data                     | csr_valid, csr_ready
//
// one vertex per cycle; each result passes the rotate, divider and project pipelines in turn
// most of the pipeline depth lies in the 47-stage restoring divider for the perspective scale
// busy is never raised and csr_ready is always high
// synchronous reset clears every valid bit and loads the default camera
// there is no stall: each result is shown for a single cycle
module camera_vertex_transform #(
   parameter int CENTER_X = 320,
   parameter int CENTER_Y = 240
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_vertex_x,
   input  logic signed [31:0] req_vertex_y,
   input  logic signed [31:0] req_vertex_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_screen_x,
   output logic signed [31:0] rsp_screen_y,
   output logic signed [31:0] rsp_view_depth,
   output logic signed [31:0] rsp_depth_scale,
   output logic               rsp_behind_camera,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import cvt_pkg::*;

   `include "camera_vertex_transform_assert.svh"

   cfg_type  cfg_ff;
   logic     rot_valid, div_valid;
   view_type rot_view, div_view;
   logic signed [31:0] div_scale;
   logic     accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_x       <= '0;
         cfg_ff.camera_y       <= '0;
         cfg_ff.camera_z       <= '0;
         cfg_ff.sine_pitch     <= '0;
         cfg_ff.cosine_pitch   <= 16'sd16384;
         cfg_ff.sine_yaw       <= '0;
         cfg_ff.cosine_yaw     <= 16'sd16384;
         cfg_ff.focal_distance <= 31'd36700160;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CAMERA_X:     cfg_ff.camera_x       <= csr_data;
            CSR_CAMERA_Y:     cfg_ff.camera_y       <= csr_data;
            CSR_CAMERA_Z:     cfg_ff.camera_z       <= csr_data;
            CSR_SINE_PITCH:   cfg_ff.sine_pitch     <= csr_data[15:0];
            CSR_COSINE_PITCH: cfg_ff.cosine_pitch   <= csr_data[15:0];
            CSR_SINE_YAW:     cfg_ff.sine_yaw       <= csr_data[15:0];
            CSR_COSINE_YAW:   cfg_ff.cosine_yaw     <= csr_data[15:0];
            CSR_FOCAL:        cfg_ff.focal_distance <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   cvt_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .vertex_x  (req_vertex_x),
      .vertex_y  (req_vertex_y),
      .vertex_z  (req_vertex_z),
      .cfg       (cfg_ff),
      .out_valid (rot_valid),
      .out_view  (rot_view)
   );

   cvt_divider u_divider (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (rot_valid),
      .in_view        (rot_view),
      .focal_distance (cfg_ff.focal_distance),
      .out_valid      (div_valid),
      .out_view       (div_view),
      .out_scale      (div_scale)
   );

   cvt_project #(
      .CENTER_X (CENTER_X),
      .CENTER_Y (CENTER_Y)
   ) u_project (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (div_valid),
      .in_view       (div_view),
      .in_scale      (div_scale),
      .out_valid     (rsp_valid),
      .screen_x      (rsp_screen_x),
      .screen_y      (rsp_screen_y),
      .view_depth    (rsp_view_depth),
      .depth_scale   (rsp_depth_scale),
      .behind_camera (rsp_behind_camera)
   );

   `CVT_ASSERT_DELAY(a_latency, rsp_valid, (start && !reset), LATENCY)
   `CVT_ASSERT(a_behind, rsp_valid |-> (rsp_behind_camera == (rsp_view_depth <= 0)))
   `CVT_ASSERT(a_zero_scale, (rsp_valid && rsp_view_depth == 0) |-> (rsp_depth_scale == S32_MAX))
   `CVT_ASSERT(a_scale_sign, (rsp_valid && rsp_view_depth > 0) |-> !rsp_depth_scale[31])
endmodule
